/* hdl/pbpm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbpm_pkg
// Shared types and constants of the packet buffer pool manager.
// ----------------------------------------------------------------------------
package pbpm_pkg;

    localparam int POOL_BUFFERS = 1024;
    localparam int IDX_W        = $clog2(POOL_BUFFERS);
    localparam int TOP_W        = IDX_W + 1;
    localparam int BULK_MAX     = 16;
    localparam int CNT_W        = $clog2(BULK_MAX + 1);
    localparam int LEN_W        = 16;
    localparam int OFF_W        = 26;

    localparam logic [LEN_W-1:0] RST_HEAD = 16'd128;
    localparam logic [LEN_W-1:0] RST_TAIL = 16'd1920;

    localparam logic [0:0] CFG_BUFFER_SIZE = 1'd0;
    localparam logic [0:0] CFG_HEADROOM    = 1'd1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOROOM = 3'd1;
    localparam logic [2:0] ST_INVAL  = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_FREE    = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_PUSH    = 3'd3;
    localparam logic [2:0] REQ_PULL    = 3'd4;
    localparam logic [2:0] REQ_PUT     = 3'd5;
    localparam logic [2:0] REQ_TRIM    = 3'd6;

    typedef enum logic [2:0] {
        OP_ALLOC, OP_FREE, OP_RELEASE, OP_PUSH, OP_PULL, OP_PUT, OP_TRIM, OP_BAD
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] amt;
    } t_req;

    typedef struct packed {
        logic             clearing;
        logic [TOP_W-1:0] free_count;
    } t_stat;

endpackage
`default_nettype wire

/* hdl/pbpm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbpm_front
// Accepts request words, decodes the request code and queues them in a two-entry queue.
// ----------------------------------------------------------------------------
module pbpm_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [31:0]          i_s_tdata,
    input  wire logic [2:0]           i_s_tuser,
    input  wire logic                 i_busy,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output pbpm_pkg::t_req            o_req
);

    pbpm_pkg::t_req r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    pbpm_pkg::t_req w_in;
    logic           w_push;

    always_comb begin
        w_in.idx = i_s_tdata[9:0];
        w_in.amt = i_s_tdata[25:10];
        case (i_s_tuser)
            pbpm_pkg::REQ_ALLOC:   w_in.op = pbpm_pkg::OP_ALLOC;
            pbpm_pkg::REQ_FREE:    w_in.op = pbpm_pkg::OP_FREE;
            pbpm_pkg::REQ_RELEASE: w_in.op = pbpm_pkg::OP_RELEASE;
            pbpm_pkg::REQ_PUSH:    w_in.op = pbpm_pkg::OP_PUSH;
            pbpm_pkg::REQ_PULL:    w_in.op = pbpm_pkg::OP_PULL;
            pbpm_pkg::REQ_PUT:     w_in.op = pbpm_pkg::OP_PUT;
            pbpm_pkg::REQ_TRIM:    w_in.op = pbpm_pkg::OP_TRIM;
            default:               w_in.op = pbpm_pkg::OP_BAD;
        endcase
    end

    assign o_s_tready = (r_cnt != 2'd2) && !i_busy;
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_req      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

endmodule
`default_nettype wire

/* hdl/pbpm_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbpm_back
// Executes queued requests: free stack, buffer table, result register.
// ----------------------------------------------------------------------------
module pbpm_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [0:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_valid,
    input  wire pbpm_pkg::t_req       i_req,
    output logic                      o_pop,
    output pbpm_pkg::t_stat           o_stat,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [95:0]               o_m_tdata,
    output logic [2:0]                o_m_tuser,
    output logic                      o_m_tlast
);

    localparam int IW = pbpm_pkg::IDX_W;
    localparam int TW = pbpm_pkg::TOP_W;
    localparam int LW = pbpm_pkg::LEN_W;
    localparam int WW = 3 * LW + 1;
    localparam logic [TW-1:0] POOL = TW'(pbpm_pkg::POOL_BUFFERS);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_APOP, S_AGRANT} t_state;

    t_state           r_state;
    logic [IW-1:0]    r_clr;
    logic [LW-1:0]    r_bsize, r_dhead;
    logic [TW-1:0]    r_top, r_min, r_final;
    logic [pbpm_pkg::CNT_W-1:0] r_left;
    pbpm_pkg::t_req   r_cur;
    logic             r_byp;
    logic [IW-1:0]    r_pos;

    logic [WW-1:0]    r_tab [pbpm_pkg::POOL_BUFFERS];
    logic [IW-1:0]    r_stk [pbpm_pkg::POOL_BUFFERS];
    logic [WW-1:0]    r_tq;
    logic [IW-1:0]    r_sq;

    logic             r_ov, r_olast;
    logic [2:0]       r_ost;
    logic [IW-1:0]    r_oidx;
    logic [LW-1:0]    r_oh, r_ot, r_ol;
    logic [pbpm_pkg::OFF_W-1:0] r_ooff;
    logic [TW-1:0]    r_ofree;

    logic             w_slot;
    logic             w_load;
    logic [IW-1:0]    w_raddr;
    logic [LW-1:0]    w_fh, w_ft, w_h, w_t, w_l;
    logic             w_rf;
    logic [2:0]       w_st;
    logic             w_dopush;
    logic [IW-1:0]    w_oidx, w_g;
    logic [pbpm_pkg::OFF_W-1:0] w_prod;
    logic [LW:0]      w_n1;
    logic [pbpm_pkg::CNT_W-1:0] w_n;

    assign w_slot  = !r_ov || i_m_tready;
    assign w_raddr = (r_state == S_IDLE) ? i_req.idx : r_cur.idx;
    assign w_fh    = (r_dhead > r_bsize) ? r_bsize : r_dhead;
    assign w_ft    = r_bsize - w_fh;
    assign w_g     = r_byp ? r_pos : r_sq;
    assign w_oidx  = (r_state == S_AGRANT) ? w_g : r_cur.idx;
    assign w_prod  = pbpm_pkg::OFF_W'(w_oidx) * pbpm_pkg::OFF_W'(r_bsize);

    // grant count: min(amount, free count, bulk limit)
    always_comb begin
        w_n1 = ({1'b0, i_req.amt} < (LW+1)'(r_top)) ? {1'b0, i_req.amt} : (LW+1)'(r_top);
        w_n  = (w_n1 > (LW+1)'(pbpm_pkg::BULK_MAX)) ? pbpm_pkg::CNT_W'(pbpm_pkg::BULK_MAX)
                                                    : w_n1[pbpm_pkg::CNT_W-1:0];
    end

    always_comb begin
        w_h      = r_tq[LW-1:0];
        w_t      = r_tq[2*LW-1:LW];
        w_l      = r_tq[3*LW-1:2*LW];
        w_rf     = r_tq[WW-1];
        w_st     = pbpm_pkg::ST_OK;
        w_dopush = 1'b0;
        case (r_cur.op)
            pbpm_pkg::OP_FREE: begin
                w_dopush = 1'b1;
            end
            pbpm_pkg::OP_RELEASE: begin
                if (!w_rf) begin
                    w_st = pbpm_pkg::ST_INVAL;
                end else begin
                    w_rf     = 1'b0;
                    w_dopush = 1'b1;
                end
            end
            pbpm_pkg::OP_PUSH: begin
                if (r_cur.amt > w_h) begin
                    w_st = pbpm_pkg::ST_NOROOM;
                end else begin
                    w_h = w_h - r_cur.amt;
                    w_l = w_l + r_cur.amt;
                end
            end
            pbpm_pkg::OP_PULL: begin
                if (r_cur.amt > w_l) begin
                    w_st = pbpm_pkg::ST_INVAL;
                end else begin
                    w_h = w_h + r_cur.amt;
                    w_l = w_l - r_cur.amt;
                end
            end
            pbpm_pkg::OP_PUT: begin
                if (r_cur.amt > w_t) begin
                    w_st = pbpm_pkg::ST_NOROOM;
                end else begin
                    w_t = w_t - r_cur.amt;
                    w_l = w_l + r_cur.amt;
                end
            end
            pbpm_pkg::OP_TRIM: begin
                if (r_cur.amt > w_l) begin
                    w_st = pbpm_pkg::ST_INVAL;
                end else begin
                    w_t = w_t + r_cur.amt;
                    w_l = w_l - r_cur.amt;
                end
            end
            default: begin
                w_st = pbpm_pkg::ST_INVAL;
            end
        endcase
        if (w_dopush && r_top >= POOL) begin
            w_st     = pbpm_pkg::ST_FULL;
            w_dopush = 1'b0;
        end
    end

    assign o_pop = (r_state == S_IDLE) && i_valid &&
                   (i_req.op != pbpm_pkg::OP_ALLOC || w_slot);

    assign w_load = ((r_state == S_IDLE) && o_pop && (i_req.op == pbpm_pkg::OP_ALLOC) &&
                     (w_n == '0)) ||
                    (((r_state == S_EXEC) || (r_state == S_AGRANT)) && w_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_bsize <= 16'd2048;
            r_dhead <= pbpm_pkg::RST_HEAD;
            r_top   <= POOL;
            r_min   <= POOL;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pbpm_pkg::CFG_BUFFER_SIZE: r_bsize <= i_cfg_data;
                    pbpm_pkg::CFG_HEADROOM:    r_dhead <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(pbpm_pkg::POOL_BUFFERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_cur <= i_req;
                        if (i_req.op != pbpm_pkg::OP_ALLOC) begin
                            r_state <= S_EXEC;
                        end else if (w_n == '0) begin
                            r_ost   <= (i_req.amt == '0) ? pbpm_pkg::ST_INVAL
                                                         : pbpm_pkg::ST_EMPTY;
                            r_oidx  <= '0;
                            r_oh    <= '0;
                            r_ot    <= '0;
                            r_ol    <= '0;
                            r_ooff  <= '0;
                            r_ofree <= r_top;
                            r_olast <= 1'b1;
                        end else begin
                            r_left  <= w_n;
                            r_final <= r_top - TW'(w_n);
                            r_state <= S_APOP;
                        end
                    end
                end
                S_EXEC: begin
                    if (w_slot) begin
                        if (w_dopush) begin
                            r_top <= r_top + 1'b1;
                        end
                        r_ost   <= w_st;
                        r_oidx  <= r_cur.idx;
                        r_oh    <= w_h;
                        r_ot    <= w_t;
                        r_ol    <= w_l;
                        r_ooff  <= w_prod + pbpm_pkg::OFF_W'(w_h);
                        r_ofree <= w_dopush ? r_top + 1'b1 : r_top;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_APOP: begin
                    // entries below the low-water mark were never written
                    r_top <= r_top - 1'b1;
                    r_pos <= IW'(r_top - 1'b1);
                    r_byp <= (r_top - 1'b1) < r_min;
                    if ((r_top - 1'b1) < r_min) begin
                        r_min <= r_top - 1'b1;
                    end
                    r_state <= S_AGRANT;
                end
                S_AGRANT: begin
                    if (w_slot) begin
                        r_ost   <= pbpm_pkg::ST_OK;
                        r_oidx  <= w_g;
                        r_oh    <= w_fh;
                        r_ot    <= w_ft;
                        r_ol    <= '0;
                        r_ooff  <= w_prod + pbpm_pkg::OFF_W'(w_fh);
                        r_ofree <= r_final;
                        r_olast <= (r_left == pbpm_pkg::CNT_W'(1));
                        r_left  <= r_left - 1'b1;
                        r_state <= (r_left == pbpm_pkg::CNT_W'(1)) ? S_IDLE : S_APOP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tq <= r_tab[w_raddr];
        if (r_state == S_CLEAR) begin
            r_tab[r_clr] <= {1'b0, 16'd0, pbpm_pkg::RST_TAIL, pbpm_pkg::RST_HEAD};
        end else if (r_state == S_EXEC && w_slot) begin
            r_tab[r_cur.idx] <= {w_rf, w_l, w_t, w_h};
        end else if (r_state == S_AGRANT && w_slot) begin
            r_tab[w_g] <= {1'b1, 16'd0, w_ft, w_fh};
        end
    end

    // stack word is captured once per pop and held while the grant waits
    always_ff @(posedge i_clk) begin
        if (r_state == S_APOP) begin
            r_sq <= r_stk[IW'(r_top - 1'b1)];
        end
        if (r_state == S_EXEC && w_slot && w_dopush) begin
            r_stk[IW'(r_top)] <= r_cur.idx;
        end
    end

    assign o_stat.clearing   = (r_state == S_CLEAR);
    assign o_stat.free_count = r_top;
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {1'b0, r_ofree, r_ooff, r_ol, r_ot, r_oh, r_oidx};

endmodule
`default_nettype wire

/* hdl/packet_buffer_pool_manager_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// packet_buffer_pool_manager_top
// Packet buffer pool manager with a LIFO free stack.
//
// Request words enter on the s channel (tuser = request code, tdata =
// buffer index, amount) and go through a two-entry queue. Result words
// leave on the m channel from one output register (tuser = status,
// tdata = index, headroom, tailroom, length, data offset, free count,
// tlast on the final result of a request).
// A table request reads the buffer table as it leaves the queue, then
// updates the table and loads the result register once the output is free.
// An alloc pops the stack (S_APOP) and grants (S_AGRANT) for each buffer,
// bounded by the single stack read port and the table write.
// After reset a clearing pass writes all 1024 buffer table entries with
// s_tready low; configuration writes are taken meanwhile.
// When the receiver stalls the output register holds; the back end waits
// and the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module packet_buffer_pool_manager_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // buffer_index[9:0], amount[25:10]
    input  wire logic [2:0]  i_s_tuser,  // req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // granted_index, headroom_out, tailroom_out, length_out, data_offset, free_left
    output logic [95:0]      o_m_tdata,
    output logic [2:0]       o_m_tuser,  // status
    output logic             o_m_tlast
);

    pbpm_pkg::t_req  w_req;
    pbpm_pkg::t_stat w_stat;
    logic            w_valid, w_pop;

    pbpm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_busy     (w_stat.clearing),
        .i_pop      (w_pop),
        .o_valid    (w_valid),
        .o_req      (w_req)
    );

    pbpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_valid),
        .i_req       (w_req),
        .o_pop       (w_pop),
        .o_stat      (w_stat),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> !o_s_tready)
        else $error("input taken during clearing pass");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.free_count <= pbpm_pkg::TOP_W'(pbpm_pkg::POOL_BUFFERS))
        else $error("free count above pool size");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == pbpm_pkg::ST_EMPTY) |-> o_m_tlast)
        else $error("pool empty result not last");

endmodule
`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_buffer_pool_manager_top. Requests are sent
// in bursts with random gaps while the result side stalls on its own
// pattern. Every result word is checked field by field against an
// in-bench model of the free stack and buffer tables. The run covers a
// directed table, random phases over several register settings, and a
// phase that drains the pool.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [2:0]                 st;
        logic [pbpm_pkg::IDX_W-1:0] idx;
        logic [15:0]                head;
        logic [15:0]                tail;
        logic [15:0]                len;
        logic [pbpm_pkg::OFF_W-1:0] off;
        logic [pbpm_pkg::TOP_W-1:0] free;
        logic                       last;
    } t_grant;

    typedef struct {
        pbpm_pkg::t_op op;
        int            idx;
        int            amt;
        bit            chk;
        logic [2:0]    st;
        int            free;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = pbpm_pkg::CFG_BUFFER_SIZE;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    packet_buffer_pool_manager_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pool model
    logic [pbpm_pkg::IDX_W-1:0] free_stack [pbpm_pkg::POOL_BUFFERS];
    int               free_top;
    logic [15:0]      head_tbl [pbpm_pkg::POOL_BUFFERS];
    logic [15:0]      tail_tbl [pbpm_pkg::POOL_BUFFERS];
    logic [15:0]      len_tbl  [pbpm_pkg::POOL_BUFFERS];
    bit               held     [pbpm_pkg::POOL_BUFFERS];
    logic [15:0]      cur_bsize = 16'd2048;
    logic [15:0]      dflt_head = 16'd128;

    t_grant     pending_words [$];
    int         owned_q [$];
    int         errors = 0;
    int         words_seen = 0;
    int         requests_sent = 0;
    int         grants = 0;
    int         burst_left = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch word %0d %s: got %0h want %0h", words_seen, what, got, want);
        errors++;
    endtask

    task automatic fresh(input int i);
        logic [15:0] h;
        h = (dflt_head > cur_bsize) ? cur_bsize : dflt_head;
        head_tbl[i] = h;
        tail_tbl[i] = cur_bsize - h;
        len_tbl[i]  = '0;
    endtask

    task automatic post(input logic [2:0] st, input int i, input bit vld, input bit last);
        t_grant g;
        g = '0;
        g.st   = st;
        g.idx  = pbpm_pkg::IDX_W'(i);
        g.free = pbpm_pkg::TOP_W'(free_top);
        g.last = last;
        if (vld) begin
            g.head = head_tbl[i];
            g.tail = tail_tbl[i];
            g.len  = len_tbl[i];
            g.off  = pbpm_pkg::OFF_W'(i * int'(cur_bsize) + int'(head_tbl[i]));
        end
        pending_words.push_back(g);
    endtask

    function automatic logic [2:0] push_free(input int i);
        if (free_top >= pbpm_pkg::POOL_BUFFERS) return pbpm_pkg::ST_FULL;
        free_stack[free_top] = pbpm_pkg::IDX_W'(i);
        free_top++;
        return pbpm_pkg::ST_OK;
    endfunction

    task automatic predict_pool(input pbpm_pkg::t_op op, input int i, input int amt,
                                output logic [2:0] st0);
        int n;
        int got [pbpm_pkg::BULK_MAX];
        logic [2:0] st;
        st = pbpm_pkg::ST_OK;
        if (op == pbpm_pkg::OP_ALLOC) begin
            n = amt;
            if (n > free_top) n = free_top;
            if (n > pbpm_pkg::BULK_MAX) n = pbpm_pkg::BULK_MAX;
            if (n == 0) begin
                st0 = (amt == 0) ? pbpm_pkg::ST_INVAL : pbpm_pkg::ST_EMPTY;
                post(st0, 0, 1'b0, 1'b1);
                return;
            end
            for (int k = 0; k < n; k++) begin
                free_top--;
                got[k] = free_stack[free_top];
                fresh(got[k]);
                held[got[k]] = 1'b1;
                owned_q.push_back(got[k]);
            end
            for (int k = 0; k < n; k++) post(pbpm_pkg::ST_OK, got[k], 1'b1, k + 1 == n);
            grants += n;
            st0 = pbpm_pkg::ST_OK;
            return;
        end
        case (op)
            pbpm_pkg::OP_FREE: st = push_free(i);
            pbpm_pkg::OP_RELEASE: begin
                if (!held[i]) st = pbpm_pkg::ST_INVAL;
                else begin
                    held[i] = 1'b0;
                    st = push_free(i);
                end
            end
            pbpm_pkg::OP_PUSH: begin
                if (amt > head_tbl[i]) st = pbpm_pkg::ST_NOROOM;
                else begin
                    head_tbl[i] -= amt;
                    len_tbl[i]  += amt;
                end
            end
            pbpm_pkg::OP_PULL: begin
                if (amt > len_tbl[i]) st = pbpm_pkg::ST_INVAL;
                else begin
                    head_tbl[i] += amt;
                    len_tbl[i]  -= amt;
                end
            end
            pbpm_pkg::OP_PUT: begin
                if (amt > tail_tbl[i]) st = pbpm_pkg::ST_NOROOM;
                else begin
                    tail_tbl[i] -= amt;
                    len_tbl[i]  += amt;
                end
            end
            pbpm_pkg::OP_TRIM: begin
                if (amt > len_tbl[i]) st = pbpm_pkg::ST_INVAL;
                else begin
                    tail_tbl[i] += amt;
                    len_tbl[i]  -= amt;
                end
            end
            default: st = pbpm_pkg::ST_INVAL;
        endcase
        st0 = st;
        post(st, i, 1'b1, 1'b1);
    endtask

    task automatic send_request(input pbpm_pkg::t_op op, input int i, input int amt,
                                output logic [2:0] st0);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {6'd0, amt[15:0], i[9:0]};
        do @(posedge i_clk); while (!o_s_tready);
        requests_sent++;
        predict_pool(op, i, amt, st0);
    endtask

    task automatic write_reg(input logic [0:0] r, input logic [15:0] v);
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (r == pbpm_pkg::CFG_BUFFER_SIZE) cur_bsize = v;
        else dflt_head = v;
    endtask

    function automatic int pick_buffer();
        if (owned_q.size() != 0 && $urandom_range(0, 3) != 0)
            return owned_q[$urandom_range(0, owned_q.size() - 1)];
        return $urandom_range(0, pbpm_pkg::POOL_BUFFERS - 1);
    endfunction

    task automatic random_request();
        int r;
        int amt;
        pbpm_pkg::t_op op;
        logic [2:0] st;
        r = $urandom_range(0, 99);
        if (r < 20) op = pbpm_pkg::OP_ALLOC;
        else if (r < 34) op = pbpm_pkg::OP_RELEASE;
        else if (r < 39) op = pbpm_pkg::OP_FREE;
        else if (r < 95)
            op = pbpm_pkg::t_op'($urandom_range(pbpm_pkg::OP_PUSH, pbpm_pkg::OP_TRIM));
        else op = pbpm_pkg::OP_BAD;
        if (op == pbpm_pkg::OP_ALLOC)
            amt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4);
        else
            amt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 300);
        send_request(op, pick_buffer(), amt, st);
    endtask

    // result side: stall pattern and checking
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge i_clk) begin
        t_grant w;
        t_grant g;
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(10, 60);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            w = {o_m_tuser, o_m_tdata[9:0], o_m_tdata[25:10], o_m_tdata[41:26],
                 o_m_tdata[57:42], o_m_tdata[83:58], o_m_tdata[94:84], o_m_tlast};
            words_seen++;
            if (pending_words.size() == 0) begin
                $display("unexpected result word %0d", words_seen);
                errors++;
            end else begin
                g = pending_words.pop_front();
                if (w.st != g.st)     report("status", w.st, g.st);
                if (w.idx != g.idx)   report("index", w.idx, g.idx);
                if (w.head != g.head) report("headroom", w.head, g.head);
                if (w.tail != g.tail) report("tailroom", w.tail, g.tail);
                if (w.len != g.len)   report("length", w.len, g.len);
                if (w.off != g.off)   report("offset", w.off, g.off);
                if (w.free != g.free) report("free", w.free, g.free);
                if (w.last != g.last) report("last", w.last, g.last);
            end
        end
    end

    initial begin
        #3000000;
        $display("timeout waiting on results");
        $display("packet_buffer_pool_manager_top regression: fail");
        $finish;
    end

    t_row dir_rows [] = '{
        '{pbpm_pkg::OP_FREE,    5,    0,     1, pbpm_pkg::ST_FULL,   1024},
        '{pbpm_pkg::OP_ALLOC,   0,    0,     1, pbpm_pkg::ST_INVAL,  1024},
        '{pbpm_pkg::OP_ALLOC,   0,    1,     1, pbpm_pkg::ST_OK,     1023},
        '{pbpm_pkg::OP_FREE,    1023, 0,     1, pbpm_pkg::ST_OK,     1024},
        '{pbpm_pkg::OP_RELEASE, 1023, 0,     1, pbpm_pkg::ST_FULL,   1024},
        '{pbpm_pkg::OP_RELEASE, 1023, 0,     1, pbpm_pkg::ST_INVAL,  1024},
        '{pbpm_pkg::OP_ALLOC,   0,    20,    1, pbpm_pkg::ST_OK,     1008},
        '{pbpm_pkg::OP_PUSH,    1023, 128,   1, pbpm_pkg::ST_OK,     1008},
        '{pbpm_pkg::OP_PUSH,    1023, 1,     1, pbpm_pkg::ST_NOROOM, 1008},
        '{pbpm_pkg::OP_PULL,    1023, 200,   1, pbpm_pkg::ST_INVAL,  1008},
        '{pbpm_pkg::OP_PULL,    1023, 128,   1, pbpm_pkg::ST_OK,     1008},
        '{pbpm_pkg::OP_PUT,     1022, 1920,  1, pbpm_pkg::ST_OK,     1008},
        '{pbpm_pkg::OP_PUT,     1022, 1,     1, pbpm_pkg::ST_NOROOM, 1008},
        '{pbpm_pkg::OP_TRIM,    1022, 65535, 1, pbpm_pkg::ST_INVAL,  1008},
        '{pbpm_pkg::OP_TRIM,    1022, 1920,  1, pbpm_pkg::ST_OK,     1008},
        '{pbpm_pkg::OP_BAD,     1000, 65535, 1, pbpm_pkg::ST_INVAL,  1008},
        '{pbpm_pkg::OP_BAD,     0,    0,     1, pbpm_pkg::ST_INVAL,  1008},
        '{pbpm_pkg::OP_RELEASE, 1022, 0,     1, pbpm_pkg::ST_OK,     1009},
        '{pbpm_pkg::OP_FREE,    0,    0,     1, pbpm_pkg::ST_OK,     1010},
        '{pbpm_pkg::OP_ALLOC,   0,    65535, 1, pbpm_pkg::ST_OK,     994},
        '{pbpm_pkg::OP_PUSH,    0,    0,     1, pbpm_pkg::ST_OK,     994},
        '{pbpm_pkg::OP_PUT,     1021, 21845, 0, pbpm_pkg::ST_OK,     0},
        '{pbpm_pkg::OP_PULL,    1020, 43690, 0, pbpm_pkg::ST_OK,     0}
    };

    logic [15:0] phase_size [6] = '{16'd1, 16'd65535, 16'd1, 16'd65535, 16'd300, 16'd2048};
    logic [15:0] phase_head [6] = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd64, 16'd128};

    initial begin
        logic [2:0] st;
        int n;
        for (int i = 0; i < pbpm_pkg::POOL_BUFFERS; i++) begin
            free_stack[i] = pbpm_pkg::IDX_W'(i);
            fresh(i);
            held[i] = 1'b0;
        end
        free_top = pbpm_pkg::POOL_BUFFERS;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].amt, st);
            if (dir_rows[k].chk) begin
                if (st != dir_rows[k].st) report("table status", st, dir_rows[k].st);
                if (free_top != dir_rows[k].free) report("table free", free_top, dir_rows[k].free);
            end
        end

        for (int p = 0; p < 6; p++) begin
            write_reg(pbpm_pkg::CFG_BUFFER_SIZE,
                      phase_size[p] == 16'd300 ? 16'($urandom_range(1, 65535)) : phase_size[p]);
            write_reg(pbpm_pkg::CFG_HEADROOM,
                      phase_head[p] == 16'd64 ? 16'($urandom_range(0, 65535)) : phase_head[p]);
            for (int k = 0; k < 20; k++) random_request();
            if (p == 2) begin
                // drain the pool, hit empty, then hand buffers back
                n = 0;
                while (n < 3) begin
                    send_request(pbpm_pkg::OP_ALLOC, $urandom_range(0, 1023), 16, st);
                    if (st == pbpm_pkg::ST_EMPTY) n++;
                end
                for (int k = 0; k < 20; k++) begin
                    n = owned_q[$urandom_range(0, owned_q.size() - 1)];
                    send_request($urandom_range(0, 3) == 0 ? pbpm_pkg::OP_FREE
                                                           : pbpm_pkg::OP_RELEASE,
                                 n, 0, st);
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("sent %0d requests, checked %0d result words, %0d buffer grants",
                 requests_sent, words_seen, grants);
        $display("six register settings including size and headroom extremes, pool drained once");
        if (errors == 0 && pending_words.size() == 0) begin
            $display("packet_buffer_pool_manager_top regression: pass");
        end else begin
            $display("packet_buffer_pool_manager_top regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/pbpm_pkg.sv
hdl/pbpm_front.sv
hdl/pbpm_back.sv
hdl/packet_buffer_pool_manager_top.sv
sim/testbench.sv
